// ===== hdl/ghal_pkg.sv =====
// Shared types and codes for the generational handle allocator.
package ghal_pkg;

  typedef enum logic [1:0] {
    FUNC_CREATE  = 2'd0,
    FUNC_DESTROY = 2'd1,
    FUNC_ALIVE   = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_UNALLOC = 2'd2
  } status_e;

  // Control from the allocator core to the free index queue.
  typedef struct packed {
    logic rd;    // read the entry at the head
    logic push;  // write an index at the tail
    logic pop;   // advance the head
  } fq_ctrl_t;

endpackage

// ===== hdl/ghal_free_queue.sv =====
// FIFO of freed indices: one synchronous memory with head, tail and fill count.
module ghal_free_queue
  import ghal_pkg::*;
#(
  parameter int unsigned INDEX_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fq_ctrl_t              ctrl_i,
  input  logic [INDEX_BITS-1:0] push_idx_i,
  output logic [INDEX_BITS-1:0] head_idx_o,
  output logic [INDEX_BITS:0]   count_o
);

  localparam int unsigned Depth = 2 ** INDEX_BITS;

  logic [INDEX_BITS-1:0] mem [Depth];
  logic [INDEX_BITS-1:0] head_q, head_d;
  logic [INDEX_BITS-1:0] tail_q, tail_d;
  logic [INDEX_BITS:0]   count_q, count_d;
  logic [INDEX_BITS-1:0] rd_data_q;

  // Storage and registered read; no reset on the payload.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[tail_q] <= push_idx_i;
    end
    if (ctrl_i.rd) begin
      rd_data_q <= mem[head_q];
    end
  end

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (ctrl_i.push) begin
      tail_d  = tail_q + INDEX_BITS'(1);
      count_d = count_q + (INDEX_BITS + 1)'(1);
    end else if (ctrl_i.pop) begin
      head_d  = head_q + INDEX_BITS'(1);
      count_d = count_q - (INDEX_BITS + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  assign head_idx_o = rd_data_q;
  assign count_o    = count_q;

endmodule

// ===== hdl/generational_handle_allocator_unit.sv =====
// Generational handle allocator: create, destroy and alive query on packed handles.
// A request goes from IDLE to EXEC, via QWAIT for a create that reuses a freed index
// (queue read, then generation read); out_valid_o rises after the commit in EXEC. No new
// request is taken until the current one commits its read-modify-write of the generation
// memory; a stalled result holds off the next request. Reset clears the queue pointers
// and fill count, sets the fresh index to 1 and loads the threshold register with 1024;
// memories are not swept, since an index gets generation 0 written when first handed out.
module generational_handle_allocator_unit
  import ghal_pkg::*;
#(
  parameter int unsigned INDEX_BITS = 12,
  parameter int unsigned GEN_BITS   = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     func_i,
  input  logic [GEN_BITS+INDEX_BITS-1:0] entity_handle_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [GEN_BITS+INDEX_BITS-1:0] new_handle_o,
  output logic                           is_alive_o,
  output logic [1:0]                     status_o,
  // threshold register write
  input  logic                           cfg_we_i,
  input  logic [INDEX_BITS:0]            cfg_wdata_i
);

  localparam int unsigned Depth       = 2 ** INDEX_BITS;
  localparam int unsigned HandleBits  = GEN_BITS + INDEX_BITS;
  localparam int unsigned MinFreeRst  = 1024;

  // Sequencer states.
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_QWAIT = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  // Create plan, decided at acceptance.
  localparam logic [1:0] PLAN_POP   = 2'd0;
  localparam logic [1:0] PLAN_FRESH = 2'd1;
  localparam logic [1:0] PLAN_FULL  = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [1:0]            plan_q, plan_d;
  logic [1:0]            func_q;
  logic [HandleBits-1:0] handle_q;
  logic [INDEX_BITS:0]   min_free_q;
  logic [INDEX_BITS:0]   next_fresh_q;

  logic                  out_valid_q;
  logic [HandleBits-1:0] new_handle_q;
  logic                  is_alive_q;
  logic [1:0]            status_q;

  logic                  in_accept;
  logic                  commit;
  logic                  fresh_exhausted;

  // Free queue hookup.
  fq_ctrl_t              fq_ctrl;
  logic [INDEX_BITS-1:0] fq_head_idx;
  logic [INDEX_BITS:0]   fq_count;
  logic [INDEX_BITS-1:0] fq_push_idx;

  // Generation memory.
  logic [GEN_BITS-1:0]   gen_mem [Depth];
  logic [GEN_BITS-1:0]   gen_rd_q;
  logic                  gen_re;
  logic [INDEX_BITS-1:0] gen_raddr;
  logic                  gen_we;
  logic [INDEX_BITS-1:0] gen_waddr;
  logic [GEN_BITS-1:0]   gen_wdata;

  // Result of the request in EXEC.
  logic [HandleBits-1:0] res_handle;
  logic                  res_alive;
  status_e               res_status;
  logic                  fresh_adv;

  // Fields of the held request.
  logic [INDEX_BITS-1:0] req_idx;
  logic [GEN_BITS-1:0]   req_gen;
  logic                  req_allocated;

  assign in_ready_o      = (state_q == S_IDLE);
  assign in_accept       = in_valid_i && in_ready_o;
  assign fresh_exhausted = next_fresh_q[INDEX_BITS];
  // Commit only when the output register is free or being drained this cycle.
  assign commit          = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  assign req_idx       = handle_q[INDEX_BITS-1:0];
  assign req_gen       = handle_q[HandleBits-1:INDEX_BITS];
  assign req_allocated = (req_idx != '0) && ({1'b0, req_idx} < next_fresh_q);

  // Decide the create path from the counters, which only move at commit.
  always_comb begin
    if ((fq_count > min_free_q) || (fresh_exhausted && (fq_count != '0))) begin
      plan_d = PLAN_POP;
    end else if (!fresh_exhausted) begin
      plan_d = PLAN_FRESH;
    end else begin
      plan_d = PLAN_FULL;
    end
  end

  // Sequencer: a reuse create reads the queue head first, then its generation.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          if ((func_i == FUNC_CREATE) && (plan_d == PLAN_POP)) begin
            state_d = S_QWAIT;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_QWAIT: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (commit) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Read the generation at the request index, or at the popped index.
  assign gen_re    = in_accept || (state_q == S_QWAIT);
  assign gen_raddr = (state_q == S_QWAIT) ? fq_head_idx
                                          : entity_handle_i[INDEX_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (gen_we) begin
      gen_mem[gen_waddr] <= gen_wdata;
    end
    if (gen_re) begin
      gen_rd_q <= gen_mem[gen_raddr];
    end
  end

  // Execute: compute the result and the write-backs, gated by commit.
  always_comb begin
    res_handle   = '0;
    res_alive    = 1'b0;
    res_status   = ST_OK;
    gen_we       = 1'b0;
    gen_waddr    = req_idx;
    gen_wdata    = gen_rd_q + GEN_BITS'(1);
    fresh_adv    = 1'b0;
    fq_ctrl.rd   = in_accept && (func_i == FUNC_CREATE) && (plan_d == PLAN_POP);
    fq_ctrl.push = 1'b0;
    fq_ctrl.pop  = 1'b0;
    fq_push_idx  = req_idx;
    unique case (func_q)
      FUNC_CREATE: begin
        unique case (plan_q)
          PLAN_POP: begin
            res_handle  = {gen_rd_q, fq_head_idx};
            fq_ctrl.pop = commit;
          end
          PLAN_FRESH: begin
            // First hand-out: define the generation as zero.
            res_handle = {GEN_BITS'(0), next_fresh_q[INDEX_BITS-1:0]};
            gen_we     = commit;
            gen_waddr  = next_fresh_q[INDEX_BITS-1:0];
            gen_wdata  = '0;
            fresh_adv  = commit;
          end
          default: begin
            res_status = ST_FULL;
          end
        endcase
      end
      FUNC_DESTROY: begin
        if (!req_allocated) begin
          res_status = ST_UNALLOC;
        end else if (fq_count[INDEX_BITS]) begin
          res_status = ST_FULL;
        end else begin
          // Bump the generation and queue the index for reuse.
          gen_we       = commit;
          fq_ctrl.push = commit;
        end
      end
      FUNC_ALIVE: begin
        if (!req_allocated) begin
          res_status = ST_UNALLOC;
        end else begin
          res_alive = (gen_rd_q == req_gen);
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  ghal_free_queue #(
    .INDEX_BITS(INDEX_BITS)
  ) u_free_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (fq_ctrl),
    .push_idx_i(fq_push_idx),
    .head_idx_o(fq_head_idx),
    .count_o   (fq_count)
  );

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      min_free_q   <= (INDEX_BITS + 1)'(MinFreeRst);
      next_fresh_q <= (INDEX_BITS + 1)'(1);
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        min_free_q <= cfg_wdata_i;
      end
      if (fresh_adv) begin
        next_fresh_q <= next_fresh_q + (INDEX_BITS + 1)'(1);
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the request and the result; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      func_q   <= func_i;
      handle_q <= entity_handle_i;
      plan_q   <= plan_d;
    end
    if (commit) begin
      new_handle_q <= res_handle;
      is_alive_q   <= res_alive;
      status_q     <= res_status;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign new_handle_o = new_handle_q;
  assign is_alive_o   = is_alive_q;
  assign status_o     = status_q;

endmodule
